// File: rtl/fcs_pkg.sv
`timescale 1ns / 1ps
// shared types, constants, a byte classifier and the fallback name for the file-name sanitizer
// no dependencies

package fcs_pkg;

  localparam int unsigned CAP_W        = 7;
  localparam int unsigned LEN_W        = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  CH_DOT       = 8'h2E;
  localparam logic [CAP_W-1:0] FALLBACK_LEN = 7'd8;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_WR2,
    ST_TRIM_RD,
    ST_TRIM_CK,
    ST_LAUNCH,
    ST_EMIT
  } fcs_state_t;

  // start request from the controller to the output stage
  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
    logic             fb;
  } emit_cmd_t;

  typedef struct packed {
    logic busy;
  } emit_sts_t;

  function automatic logic is_sep(input logic [7:0] b);
    logic r;
    r = (b <= CH_SPACE) ||
        (b inside {8'h3C, 8'h3E, 8'h3A, 8'h22, 8'h2F, 8'h5C, 8'h7C, 8'h3F, 8'h2A});
    return r;
  endfunction

  // "untitled"
  function automatic logic [7:0] fallback_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h75;
      3'd1:    c = 8'h6E;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h69;
      3'd4:    c = 8'h74;
      3'd5:    c = 8'h6C;
      3'd6:    c = 8'h65;
      3'd7:    c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/fcs_ram.sv
`timescale 1ns / 1ps
// name buffer: one write port, one read port with registered data
// no dependencies

module fcs_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/fcs_ctrl.sv
`timescale 1ns / 1ps
// input side: collapse separators, fill the buffer, trim trailing dots/spaces
// depends on fcs_pkg

module fcs_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [fcs_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_byte,
  input  logic                    in_end,
  output logic                    wr_en,
  output logic [AW-1:0]           wr_addr,
  output logic [7:0]              wr_data,
  output logic                    rd_en,
  output logic [AW-1:0]           rd_addr,
  input  logic [7:0]              rd_data,
  output fcs_pkg::emit_cmd_t      cmd,
  input  fcs_pkg::emit_sts_t      sts
);

  import fcs_pkg::*;

  fcs_state_t     state_r, state_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [AW-1:0]  wc_r, wc_nxt;
  logic           pend_r, pend_nxt;
  logic           full_r, full_nxt;
  logic [7:0]     hold_r, hold_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;

  logic [CAP_W-1:0] cap_cl, lim7, fl7;
  logic [AW-1:0]  limit, flen, len0;
  logic [AW:0]    wc_inc;
  logic           acc, sep, wc_full, wc_inc_full, trim_hit, idx_zero;

  // current limit: capacity clamped to the buffer depth, minus one
  assign cap_cl = (cap_r > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_r;
  assign lim7   = (cap_cl == '0) ? '0 : cap_cl - 1'b1;
  assign limit  = lim7[AW-1:0];
  assign fl7    = (lim7 > FALLBACK_LEN) ? FALLBACK_LEN : lim7;
  assign flen   = fl7[AW-1:0];

  assign acc         = in_tvalid && in_tready;
  assign sep         = is_sep(in_byte);
  assign wc_full     = (wc_r >= limit);
  assign wc_inc      = (AW+1)'(wc_r) + 1'b1;
  assign wc_inc_full = (wc_inc >= (AW+1)'(limit));
  assign len0        = (wc_r > limit) ? limit : wc_r;
  assign trim_hit    = (rd_data == CH_DOT) || (rd_data == CH_SPACE);
  assign idx_zero    = (idx_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (acc) begin
          if (in_end) begin
            state_nxt = ST_TRIM_RD;
          end else if (!full_r && !sep && pend_r && !wc_full && !wc_inc_full) begin
            state_nxt = ST_WR2;
          end
        end
      end
      ST_WR2:     state_nxt = ST_FILL;
      ST_TRIM_RD: state_nxt = idx_zero ? ST_LAUNCH : ST_TRIM_CK;
      ST_TRIM_CK: state_nxt = trim_hit ? ST_TRIM_RD : ST_LAUNCH;
      ST_LAUNCH:  state_nxt = ST_EMIT;
      ST_EMIT:    state_nxt = sts.busy ? ST_EMIT : ST_FILL;
      default:    state_nxt = ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = wc_r;
    wr_data   = in_byte;
    rd_en     = 1'b0;
    rd_addr   = idx_r - 1'b1;
    cmd       = '0;
    case (state_r)
      ST_FILL: begin
        in_tready = 1'b1;
        if (acc && !in_end && !full_r && !sep && !wc_full) begin
          wr_en   = 1'b1;
          wr_data = pend_r ? CH_SPACE : in_byte;
        end
      end
      ST_WR2: begin
        wr_en   = 1'b1;
        wr_data = hold_r;
      end
      ST_TRIM_RD: begin
        rd_en = !idx_zero;
      end
      ST_LAUNCH: begin
        cmd.start = 1'b1;
        cmd.fb    = idx_zero;
        cmd.len   = LEN_W'(idx_zero ? flen : idx_r);
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    wc_nxt   = wc_r;
    pend_nxt = pend_r;
    full_nxt = full_r;
    hold_nxt = hold_r;
    idx_nxt  = idx_r;
    case (state_r)
      ST_FILL: begin
        if (acc && in_end) begin
          idx_nxt  = len0;
          wc_nxt   = '0;
          pend_nxt = 1'b0;
          full_nxt = 1'b0;
        end else if (acc && !full_r) begin
          if (sep) begin
            if (wc_r != '0) pend_nxt = 1'b1;
          end else if (wc_full) begin
            full_nxt = 1'b1;
          end else if (pend_r) begin
            // space goes now, the byte in the next cycle if it still fits
            wc_nxt   = wc_inc[AW-1:0];
            pend_nxt = 1'b0;
            hold_nxt = in_byte;
            if (wc_inc_full) full_nxt = 1'b1;
          end else begin
            wc_nxt = wc_inc[AW-1:0];
          end
        end
      end
      ST_WR2: begin
        wc_nxt = wc_inc[AW-1:0];
      end
      ST_TRIM_CK: begin
        if (trim_hit) idx_nxt = idx_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      cap_r   <= CAP_RESET;
      wc_r    <= '0;
      pend_r  <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wc_r    <= wc_nxt;
      pend_r  <= pend_nxt;
      full_r  <= full_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    idx_r  <= idx_nxt;
  end

endmodule

// File: rtl/fcs_emit.sv
`timescale 1ns / 1ps
// output side: fetch stage over the buffer or the fallback word, then output register
// depends on fcs_pkg

module fcs_emit #(
  parameter int unsigned AW = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fcs_pkg::emit_cmd_t        cmd,
  output fcs_pkg::emit_sts_t        sts,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic [7:0]                rd_data,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_char,
  output logic                      out_cvalid,
  output logic                      out_last,
  output logic [fcs_pkg::LEN_W-1:0] out_len
);

  import fcs_pkg::*;

  logic [AW-1:0]    len_r, p_r, f_idx_r;
  logic             fb_r, ez_r, f_v_r, f_ez_r;
  logic             o_v_r, o_cv_r, o_last_r;
  logic [7:0]       o_char_r;
  logic [LEN_W-1:0] o_len_r;

  logic             more, move, fetch;
  logic [7:0]       f_char;
  logic [CAP_W-1:0] f_idx7;

  assign more  = (p_r < len_r) || ez_r;
  assign move  = f_v_r && (!o_v_r || out_tready);
  assign fetch = more && (!f_v_r || move);

  assign rd_en   = fetch && !fb_r && !ez_r;
  assign rd_addr = p_r;

  assign f_idx7 = CAP_W'(f_idx_r);
  assign f_char = f_ez_r ? 8'h00 : (fb_r ? fallback_char(f_idx7[2:0]) : rd_data);

  assign sts.busy = more || f_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      p_r   <= '0;
      ez_r  <= 1'b0;
      f_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        len_r <= cmd.len[AW-1:0];
        p_r   <= '0;
        ez_r  <= (cmd.len == '0);
      end else if (fetch) begin
        if (ez_r) ez_r <= 1'b0;
        else      p_r  <= p_r + 1'b1;
      end
      if (fetch)     f_v_r <= 1'b1;
      else if (move) f_v_r <= 1'b0;
      if (move)            o_v_r <= 1'b1;
      else if (out_tready) o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) fb_r <= cmd.fb;
    if (fetch) begin
      f_idx_r <= p_r;
      f_ez_r  <= ez_r;
    end
    if (move) begin
      o_char_r <= f_char;
      o_cv_r   <= !f_ez_r;
      o_last_r <= f_ez_r || (f_idx_r == len_r - 1'b1);
      o_len_r  <= LEN_W'(len_r);
    end
  end

  assign out_tvalid = o_v_r;
  assign out_char   = o_char_r;
  assign out_cvalid = o_cv_r;
  assign out_last   = o_last_r;
  assign out_len    = o_len_r;

endmodule

// File: rtl/filename_component_sanitizer.sv
`timescale 1ns / 1ps
// top level of the file-name component sanitizer
// depends on fcs_pkg, fcs_ram, fcs_ctrl, fcs_emit
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  in_      | slave     | in_tvalid/in_tready  | tdata: char_byte; tlast: end_of_name
//  out_     | master    | out_tvalid/out_tready| tdata: out_char, name_length; tuser:
//           |           |                      | char_valid; tlast: last_of_name
//  cfg_     | write     | cfg_wr_en            | cfg_wr_data: dest_capacity
//
// input: the first content byte after a run of separators is written in ST_WR2, with the
//   input closed, after the collapsed space when both fit, since both go through the single
//   buffer write port
// end of name: the accept, then a buffer read and a check per character checked from the tail
//   (the check that stops the trim included), one more read state when nothing is left, the
//   launch, then the result items and the drain of the fetch stage before the input reopens
// reset: synchronous active low, clears the name state and sets dest_capacity to 64;
//   the buffer itself is not cleared
// stalls: out_tready low holds the output register and the fetch stage; input stays
//   closed until every byte of the name has left the buffer

module filename_component_sanitizer #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [fcs_pkg::CAP_W-1:0] cfg_wr_data,  // dest_capacity
  // raw bytes
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,     // [7:0] char_byte
  input  logic                      in_tlast,     // end_of_name
  // sanitized bytes
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,    // [7:0] out_char, [13:8] name_length
  output logic                      out_tuser,    // char_valid
  output logic                      out_tlast     // last_of_name
);

  import fcs_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic          wr_en, c_rd_en, e_rd_en, rd_en;
  logic [AW-1:0] wr_addr, c_rd_addr, e_rd_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;
  emit_cmd_t     cmd;
  emit_sts_t     sts;
  logic [7:0]    o_char;
  logic [LEN_W-1:0] o_len;

  fcs_ram #(.DEPTH(BUFFER_DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fcs_ctrl #(.DEPTH(BUFFER_DEPTH), .AW(AW)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_byte     (in_tdata),
    .in_end      (in_tlast),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (c_rd_en),
    .rd_addr     (c_rd_addr),
    .rd_data     (rd_data),
    .cmd         (cmd),
    .sts         (sts)
  );

  fcs_emit #(.AW(AW)) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .rd_en      (e_rd_en),
    .rd_addr    (e_rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (o_char),
    .out_cvalid (out_tuser),
    .out_last   (out_tlast),
    .out_len    (o_len)
  );

  // trim and emit never read in the same cycle
  assign rd_en   = c_rd_en | e_rd_en;
  assign rd_addr = e_rd_en ? e_rd_addr : c_rd_addr;

  assign out_tdata = {2'b00, o_len, o_char};

  // input must stay closed while the buffer is still being read out
  a_no_input_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !in_tready)
    else $error("input open while name is being emitted");

  // an item without a byte is the only item of an empty name
  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && out_tdata[13:8] == '0))
    else $error("empty item malformed");

  // buffer writes never overlap the read-out
  a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && e_rd_en))
    else $error("buffer written during read-out");

  // a new name is launched only once the previous one has left the fetch stage
  a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !sts.busy)
    else $error("launch while emit busy");

endmodule
